// ===== design/plbc_pkg.sv =====
// Shared types and constants for the path length and bending cost block.
`timescale 1ns / 1ps
package plbc_pkg;
   localparam int unsigned SUM_W = 48;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam int unsigned COORD_W = 32;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_SQ    = 10'b0000000010,
      ST_SQRT  = 10'b0000000100,
      ST_VR    = 10'b0000001000,
      ST_VL    = 10'b0000010000,
      ST_DVSQ  = 10'b0000100000,
      ST_BDIV  = 10'b0001000000,
      ST_BACC  = 10'b0010000000,
      ST_NEXT  = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;
endpackage

// ===== design/plbc_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module plbc_mul import plbc_pkg::*; #(
   parameter int W = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic           busy,
   output logic [2*W-1:0] prod
);
   logic [2*W-1:0] acc_ff, acc_in;
   logic [W-1:0]   b_ff, b_in;
   logic [2*W-1:0] a_ff, a_in;
   logic [$clog2(W+1)-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;

   always_comb begin
      acc_in = acc_ff; b_in = b_ff; a_in = a_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         acc_in = '0; a_in = {{W{1'b0}}, a}; b_in = b;
         cnt_in = ($clog2(W+1))'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) acc_in = acc_ff + a_ff;
         a_in = a_ff << 1;
         b_in = b_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ($clog2(W+1))'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; a_ff <= a_in; b_ff <= b_in; cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign prod = acc_ff;
endmodule

// ===== design/plbc_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module plbc_div import plbc_pkg::*; #(
   parameter int NW = 128,
   parameter int DW = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quo
);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW:0]   t;
   logic [$clog2(NW+1)-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] d_ff, d_in;
   logic busy_ff, busy_in;

   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; d_in = d_ff; busy_in = busy_ff;
      t = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den;
         cnt_in = ($clog2(NW+1))'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (t >= {1'b0, d_ff}) begin
            r_in = t - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = t;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ($clog2(NW+1))'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; cnt_ff <= cnt_in; d_ff <= d_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign quo  = q_ff;
endmodule

// ===== design/path_length_bending_cost.sv =====
// Top level: running path length and bending cost of a joint-space path.
//
// Input channel req_*: one waypoint beat (first_point, coord_0..5, time_stamp),
// accepted when req_valid is high and req_stall is low. Result channel rsp_*:
// one beat per waypoint (total_length, total_bending, time_error, saturated),
// taken when rsp_valid is high and rsp_stall is low.
// One waypoint is processed at a time on a shared 64-bit serial multiplier
// and a 128-bit serial divider. A path start passes through ST_NEXT and
// ST_OUT, which raises rsp_valid. A later point adds six squared differences
// and a 36-step root probe. With a bending term each joint adds two velocity
// divisions, a square, a division and an accumulate step.
// req_stall is high from acceptance until the result beat is taken; the next
// waypoint can enter the cycle after that, so a new waypoint is never taken
// while the last one's result is pending.
// While rsp_stall is high the result holds and no new waypoint enters.
// Synchronous reset clears the sums, history and handshake state; the first
// waypoint after reset acts as a path start.
`timescale 1ns / 1ps
module path_length_bending_cost import plbc_pkg::*; #(
   parameter int JOINTS    = 6,
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_first_point,
   input  logic signed [31:0]  req_coord_0,
   input  logic signed [31:0]  req_coord_1,
   input  logic signed [31:0]  req_coord_2,
   input  logic signed [31:0]  req_coord_3,
   input  logic signed [31:0]  req_coord_4,
   input  logic signed [31:0]  req_coord_5,
   input  logic [31:0]         req_time_stamp,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [47:0]         rsp_total_length,
   output logic [47:0]         rsp_total_bending,
   output logic                rsp_time_error,
   output logic                rsp_saturated
);
   localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

   state_type state_ff, state_in;
   logic [31:0] cur_ff [6];
   logic [31:0] prev_ff [6];
   logic [31:0] old_ff [6];
   logic [31:0] ptime_ff, otime_ff, ctime_ff;
   logic [1:0]  seen_ff;
   logic [47:0] len_ff, bend_ff;
   logic        sat_ff, terr_ff, bend_ok_ff, valid_ff;
   logic [JW-1:0] j_ff;
   logic [69:0] sq_ff;
   logic [35:0] root_ff;
   logic [5:0]  bit_ff;
   logic signed [63:0] vr_ff, vl_ff;
   logic        go_ff;

   // unit operands
   logic         m_start, m_busy, d_start, d_busy;
   logic [63:0]  ma, mb;
   logic [127:0] mp;
   logic [127:0] dn, dq;
   logic [63:0]  dd;

   logic signed [32:0] dcur, dprv;
   logic [63:0] mag_c, mag_p;
   logic [35:0] cand, root_nx;
   logic signed [64:0] dv;
   logic [63:0] dvmag;
   logic [32:0] dtl, dtr;
   logic [48:0] lsum, bsum;
   logic        accept;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || valid_ff;

   assign dcur  = $signed({cur_ff[j_ff][31], cur_ff[j_ff]}) -
                  $signed({prev_ff[j_ff][31], prev_ff[j_ff]});
   assign dprv  = $signed({prev_ff[j_ff][31], prev_ff[j_ff]}) -
                  $signed({old_ff[j_ff][31], old_ff[j_ff]});
   assign mag_c = dcur[32] ? 64'(-dcur) : 64'(dcur);
   assign mag_p = dprv[32] ? 64'(-dprv) : 64'(dprv);
   assign cand  = root_ff | (36'd1 << bit_ff);
   assign root_nx = (mp[71:0] <= {2'd0, sq_ff}) ? cand : root_ff;
   assign dtl   = {1'b0, ptime_ff} - {1'b0, otime_ff};
   assign dtr   = {1'b0, ctime_ff} - {1'b0, ptime_ff};
   assign dv    = {vr_ff[63], vr_ff} - {vl_ff[63], vl_ff};
   assign dvmag = dv[64] ? 64'(-dv) : 64'(dv);
   assign lsum  = {1'b0, len_ff} + {13'd0, root_nx};

   plbc_mul #(.W(64)) u_mul (
      .clock(clock), .reset(reset), .start(m_start),
      .a(ma), .b(mb), .busy(m_busy), .prod(mp)
   );
   plbc_div #(.NW(128), .DW(64)) u_div (
      .clock(clock), .reset(reset), .start(d_start),
      .num(dn), .den(dd), .busy(d_busy), .quo(dq)
   );

   // unit launch: go_ff marks the first cycle of a state and of each further step in ST_SQ and ST_SQRT
   always_comb begin
      m_start = 1'b0; d_start = 1'b0;
      ma = '0; mb = '0; dn = '0; dd = '0;
      case (state_ff)
         ST_SQ:   begin m_start = go_ff; ma = mag_c; mb = mag_c; end
         ST_SQRT: begin m_start = go_ff; ma = {28'd0, cand}; mb = {28'd0, cand}; end
         ST_VR: begin
            d_start = go_ff;
            dn = {64'd0, mag_c} << FRAC_BITS; dd = {31'd0, dtr};
         end
         ST_VL: begin
            d_start = go_ff;
            dn = {64'd0, mag_p} << FRAC_BITS; dd = {31'd0, dtl};
         end
         ST_DVSQ: begin m_start = go_ff; ma = dvmag; mb = dvmag; end
         ST_BDIV: begin
            d_start = go_ff; dn = mp << 1; dd = {31'd0, dtl} + {31'd0, dtr};
         end
         default: ;
      endcase
   end

   assign bsum = {1'b0, bend_ff} + {1'b0, dq[47:0]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept)
            state_in = (seen_ff != 2'd0 && !req_first_point) ? ST_SQ : ST_NEXT;
         ST_SQ: if (!go_ff && !m_busy)
            state_in = (j_ff == JW'(JOINTS-1)) ? ST_SQRT : ST_SQ;
         ST_SQRT: if (!go_ff && !m_busy && bit_ff == 6'd0)
            state_in = bend_ok_ff ? ST_VR : ST_NEXT;
         ST_VR:   if (!go_ff && !d_busy) state_in = ST_VL;
         ST_VL:   if (!go_ff && !d_busy) state_in = ST_DVSQ;
         ST_DVSQ: if (!go_ff && !m_busy) state_in = ST_BDIV;
         ST_BDIV: if (!go_ff && !d_busy) state_in = ST_BACC;
         ST_BACC: state_in = (j_ff == JW'(JOINTS-1)) ? ST_NEXT : ST_VR;
         ST_NEXT: state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; valid_ff <= 1'b0; seen_ff <= '0;
         len_ff <= '0; bend_ff <= '0; sat_ff <= 1'b0; go_ff <= 1'b0;
         ptime_ff <= '0; otime_ff <= '0;
         for (int k = 0; k < 6; k++) begin prev_ff[k] <= '0; old_ff[k] <= '0; end
      end else begin
         state_ff <= state_in;
         go_ff <= (state_in != state_ff) ||
                  (state_ff == ST_SQ && !go_ff && !m_busy) ||
                  (state_ff == ST_SQRT && !go_ff && !m_busy);
         if (valid_ff && !rsp_stall) valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (accept) begin
               cur_ff[0] <= req_coord_0; cur_ff[1] <= req_coord_1;
               cur_ff[2] <= req_coord_2; cur_ff[3] <= req_coord_3;
               cur_ff[4] <= req_coord_4; cur_ff[5] <= req_coord_5;
               ctime_ff <= req_time_stamp;
               j_ff <= '0; sq_ff <= '0; root_ff <= '0; bit_ff <= 6'd35;
               if (req_first_point) begin
                  seen_ff <= '0; len_ff <= '0; bend_ff <= '0; sat_ff <= 1'b0;
                  terr_ff <= 1'b0; bend_ok_ff <= 1'b0;
               end else begin
                  terr_ff <= (seen_ff != 2'd0) && (req_time_stamp <= ptime_ff);
                  bend_ok_ff <= (seen_ff == 2'd2) && (req_time_stamp > ptime_ff) &&
                                (ptime_ff > otime_ff);
               end
            end
            ST_SQ: if (!go_ff && !m_busy) begin
               sq_ff <= sq_ff + mp[69:0];
               if (j_ff != JW'(JOINTS-1)) j_ff <= j_ff + 1'b1;
            end
            ST_SQRT: if (!go_ff && !m_busy) begin
               root_ff <= root_nx;
               if (bit_ff != 6'd0) bit_ff <= bit_ff - 1'b1;
               else begin
                  j_ff <= '0;
                  if (lsum[48]) begin len_ff <= SUM_MAX; sat_ff <= 1'b1; end
                  else len_ff <= lsum[47:0];
               end
            end
            ST_VR: if (!go_ff && !d_busy)
               vr_ff <= dcur[32] ? -$signed(dq[63:0]) : $signed(dq[63:0]);
            ST_VL: if (!go_ff && !d_busy)
               vl_ff <= dprv[32] ? -$signed(dq[63:0]) : $signed(dq[63:0]);
            ST_BACC: begin
               if ((|dq[127:48]) || bsum[48]) begin
                  bend_ff <= SUM_MAX; sat_ff <= 1'b1;
               end else bend_ff <= bsum[47:0];
               if (j_ff != JW'(JOINTS-1)) j_ff <= j_ff + 1'b1;
            end
            ST_NEXT: begin
               for (int k = 0; k < 6; k++) begin
                  old_ff[k] <= prev_ff[k]; prev_ff[k] <= cur_ff[k];
               end
               otime_ff <= ptime_ff; ptime_ff <= ctime_ff;
               if (seen_ff != 2'd2) seen_ff <= seen_ff + 1'b1;
            end
            ST_OUT: valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_total_length  = len_ff;
   assign rsp_total_bending = bend_ff;
   assign rsp_time_error    = terr_ff;
   assign rsp_saturated     = sat_ff;
endmodule

// ===== design/plbc_checker.sv =====
// Port-level checks for the path length and bending cost block.
`timescale 1ns / 1ps
module plbc_checker import plbc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [47:0] rsp_total_length,
   input logic [47:0] rsp_total_bending,
   input logic        rsp_saturated
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_total_length))
      else $error("result beat dropped while stalled");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat taken while busy");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_total_length == SUM_MAX) || (rsp_total_bending == SUM_MAX))
      else $error("saturated without a full sum");
endmodule

bind path_length_bending_cost plbc_checker u_plbc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_total_length(rsp_total_length), .rsp_total_bending(rsp_total_bending),
   .rsp_saturated(rsp_saturated)
);
